### src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge, off while in reset
`define SSIG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following edge, off while in reset
`define SSIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ssig_pkg.sv
// Shared constants, opcodes and controller/datapath interface types
package ssig_pkg;

    // store depth default and fixed field widths
    localparam int DEPTH_DEFAULT = 1024;
    localparam int VAL_W         = 32;
    localparam int POS_W         = 10;
    localparam int OP_W          = 2;

    // request opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // store read address source
    typedef enum logic [1:0] {
        RD_CUR,
        RD_GAL,
        RD_MID
    } t_rd_sel;

    // cursor source when a probe finishes
    typedef enum logic [1:0] {
        FIN_KEEP,
        FIN_CUR,
        FIN_MID,
        FIN_LO0
    } t_fin_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     clear;
        logic     probe_start;
        t_rd_sel  rd_sel;
        logic     gal_double;
        logic     bs_setup;
        logic     bs_read;
        logic     bs_go_hi;
        logic     bs_go_lo;
        logic     finish;
        logic     fin_found;
        t_fin_sel fin_sel;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic key_eq;
        logic key_lt;
        logic gal_in;
        logic lo_gt_hi;
        logic mid_eq_lo;
    } t_status;

endpackage

### src/ssig_dpath.sv
// Datapath: entry store, search registers, cursor and result registers
module ssig_dpath
    import ssig_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VAL_W-1:0] i_value,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_valid,
    output logic             o_found,
    output logic [POS_W-1:0] o_position,
    output logic [VAL_W-1:0] o_match_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    logic [VAL_W-1:0] r_store [DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic [VAL_W-1:0] r_key;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_cursor;
    logic [AW-1:0]    r_cur;
    logic [SW-1:0]    r_step;
    logic [AW-1:0]    r_lo0;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hi;
    logic [AW-1:0]    r_mid;
    logic             r_valid;
    logic             r_found;
    logic [POS_W-1:0] r_position;
    logic [VAL_W-1:0] r_match;

    logic [CW-1:0]    w_last;
    logic [AW-1:0]    w_cur_start;
    logic [SW-1:0]    w_gal_sum;
    logic [SW-1:0]    w_lo0;
    logic [CW-1:0]    w_hi;
    logic [CW-1:0]    w_mid_full;
    logic [AW-1:0]    w_mid;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    n_cursor;
    logic [PW-1:0]    w_pos_ext;

    // search arithmetic
    assign w_last      = r_count - CW'(1);
    assign w_cur_start = (CW'(r_cursor) >= r_count) ? w_last[AW-1:0] : r_cursor;
    assign w_gal_sum   = SW'(r_cur) + r_step;
    assign w_lo0       = SW'(r_cur) + (r_step >> 1);
    assign w_hi        = (w_gal_sum > SW'(w_last)) ? w_last : w_gal_sum[CW-1:0];
    assign w_mid_full  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_mid       = w_mid_full[AW-1:0];

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_CUR:  w_rd_addr = r_cur;
            RD_GAL:  w_rd_addr = w_gal_sum[AW-1:0];
            RD_MID:  w_rd_addr = w_mid;
            default: w_rd_addr = r_cur;
        endcase
    end

    // cursor after a finished probe
    always_comb begin
        case (i_cmd.fin_sel)
            FIN_KEEP: n_cursor = r_cursor;
            FIN_CUR:  n_cursor = r_cur;
            FIN_MID:  n_cursor = r_mid;
            FIN_LO0:  n_cursor = r_lo0;
            default:  n_cursor = r_cursor;
        endcase
    end

    assign w_pos_ext = PW'(n_cursor);

    // status back to the controller
    assign o_status.count_zero = (r_count == '0);
    assign o_status.key_eq     = (r_rdata == r_key);
    assign o_status.key_lt     = ($signed(r_rdata) < $signed(r_key));
    assign o_status.gal_in     = (w_gal_sum < SW'(r_count));
    assign o_status.lo_gt_hi   = (r_lo > r_hi);
    assign o_status.mid_eq_lo  = (CW'(r_mid) == r_lo);

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(DEPTH))) begin
            r_store[r_count[AW-1:0]] <= i_value;
        end
        r_rdata <= r_store[w_rd_addr];
    end

    // control state: fill count, cursor, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.clear) begin
                r_count  <= '0;
                r_cursor <= '0;
            end else begin
                if (i_cmd.load && (r_count < CW'(DEPTH))) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.finish) begin
                    r_cursor <= n_cursor;
                end
            end
        end
    end

    // search working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_start) begin
            r_key  <= i_value;
            r_cur  <= w_cur_start;
            r_step <= SW'(1);
        end
        if (i_cmd.gal_double) begin
            r_step <= r_step << 1;
        end
        if (i_cmd.bs_setup) begin
            r_lo0 <= w_lo0[AW-1:0];
            r_lo  <= w_lo0[CW-1:0];
            r_hi  <= w_hi;
        end
        if (i_cmd.bs_read) begin
            r_mid <= w_mid;
        end
        if (i_cmd.bs_go_hi) begin
            r_lo <= CW'(r_mid) + CW'(1);
        end
        if (i_cmd.bs_go_lo) begin
            r_hi <= CW'(r_mid) - CW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found    <= i_cmd.fin_found;
            r_position <= w_pos_ext[POS_W-1:0];
            r_match    <= r_key;
        end
    end

    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_match_value = r_match;

endmodule

### src/ssig_ctrl.sv
// Controller: request decode and gallop / binary search sequencing
module ssig_ctrl
    import ssig_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_opcode,
    input  t_status         i_status,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EMPTY    = 9'b000000010,
        S_RD_CUR   = 9'b000000100,
        S_CMP_CUR  = 9'b000001000,
        S_GAL_RD   = 9'b000010000,
        S_GAL_CMP  = 9'b000100000,
        S_BS_SETUP = 9'b001000000,
        S_BS_RD    = 9'b010000000,
        S_BS_CMP   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        OP_LOAD:  o_cmd.load = 1'b1;
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        OP_PROBE: begin
                            o_cmd.probe_start = 1'b1;
                            n_state = i_status.count_zero ? S_EMPTY : S_RD_CUR;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMPTY: begin
                o_cmd.finish  = 1'b1;
                o_cmd.fin_sel = FIN_KEEP;
                n_state       = S_IDLE;
            end
            S_RD_CUR: begin
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_CMP_CUR;
            end
            S_CMP_CUR: begin
                if (i_status.key_eq) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.fin_found = 1'b1;
                    o_cmd.fin_sel   = FIN_CUR;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_GAL_RD;
                end
            end
            S_GAL_RD: begin
                if (i_status.gal_in) begin
                    o_cmd.rd_sel = RD_GAL;
                    n_state      = S_GAL_CMP;
                end else begin
                    n_state = S_BS_SETUP;
                end
            end
            S_GAL_CMP: begin
                if (i_status.key_lt) begin
                    o_cmd.gal_double = 1'b1;
                    n_state          = S_GAL_RD;
                end else begin
                    n_state = S_BS_SETUP;
                end
            end
            S_BS_SETUP: begin
                o_cmd.bs_setup = 1'b1;
                n_state        = S_BS_RD;
            end
            S_BS_RD: begin
                if (i_status.lo_gt_hi) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.fin_sel = FIN_LO0;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.bs_read = 1'b1;
                    o_cmd.rd_sel  = RD_MID;
                    n_state       = S_BS_CMP;
                end
            end
            S_BS_CMP: begin
                if (i_status.key_eq) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.fin_found = 1'b1;
                    o_cmd.fin_sel   = FIN_MID;
                    n_state         = S_IDLE;
                end else if (i_status.key_lt) begin
                    o_cmd.bs_go_hi = 1'b1;
                    n_state        = S_BS_RD;
                end else if (i_status.mid_eq_lo) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.fin_sel = FIN_LO0;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.bs_go_lo = 1'b1;
                    n_state        = S_BS_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### src/sorted_set_intersection_gallop.sv
// Top level: sorted set intersection by galloping search
// Usage:
//   A request is taken on the rising edge where start is high and busy is low.
//   Opcode load appends value to the store (dropped once DEPTH entries are
//   held); clear empties the store and sets the cursor to zero; opcode 3 is
//   ignored. These give no result and never raise busy.
//   Opcode probe looks value up from the kept cursor: a gallop over offsets
//   1, 2, 4, ... then a binary search inside the bracket found. One result
//   (o_found, o_position, o_match_value) follows, marked by o_valid for
//   exactly one cycle; the receiver has no way to hold it off.
// Probe sequencing:
//   Probe of an empty store: a miss result, with the cursor kept.
//   Hit at the cursor: one store read and one compare. Otherwise each gallop
//   step and each binary step is one store read, then one compare, as the
//   single registered read port of the store allows; one probe is worked on
//   at a time, and busy is low again in the cycle its result is shown.
// Reset (synchronous, active low) empties the store and zeroes the cursor;
// store contents need no clearing since only loaded entries are read.
`include "assert_macros.svh"

module sorted_set_intersection_gallop
    import ssig_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    output logic             o_found,
    output logic [POS_W-1:0] o_position,
    output logic [VAL_W-1:0] o_match_value
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_accept;
    logic    w_short_req;
    logic    w_step_cmd;

    assign w_accept = start && !busy;

    // sequencing
    ssig_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // store and search registers
    ssig_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_match_value (o_match_value)
    );

    // check terms
    assign w_short_req = w_accept && (i_opcode != OP_PROBE);
    assign w_step_cmd  = w_cmd.bs_read || w_cmd.gal_double;

    // checks
    `SSIG_ASSERT_IMPL(a_result_after_search, o_valid, $past(busy), "result with no probe")
    `SSIG_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "two results on consecutive cycles")
    `SSIG_ASSERT_NEXT(a_short_request_idle, w_short_req, !busy && !o_valid, "non-probe busy")
    `SSIG_ASSERT_IMPL(a_one_command, w_cmd.finish, !w_step_cmd, "finish with a search step")

endmodule
